[hw/rtl/tof_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tof_pkg;

  // telnet protocol bytes
  localparam logic [7:0] B_IAC  = 8'd255;
  localparam logic [7:0] B_DONT = 8'd254;
  localparam logic [7:0] B_DO   = 8'd253;
  localparam logic [7:0] B_WONT = 8'd252;
  localparam logic [7:0] B_WILL = 8'd251;
  localparam logic [7:0] B_SB   = 8'd250;
  localparam logic [7:0] B_SE   = 8'd240;

  localparam logic [7:0] OPT_ECHO  = 8'd1;
  localparam logic [7:0] OPT_TTYPE = 8'd24;
  localparam logic [7:0] OPT_COMP2 = 8'd86;
  localparam logic [7:0] OPT_MSSP  = 8'd70;
  localparam logic [7:0] TT_IS     = 8'd0;
  localparam logic [7:0] TT_SEND   = 8'd1;

  // input actions
  localparam logic [1:0] ACT_NET     = 2'd0;
  localparam logic [1:0] ACT_HOST    = 2'd1;
  localparam logic [1:0] ACT_CONNECT = 2'd2;

  // job queue between parser and emitter
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic       to_network;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       echo_enabled;
  } out_word_t;

  typedef enum logic [2:0] {
    JOB_TO_HOST = 3'd0,
    JOB_TO_NET  = 3'd1,
    JOB_TRIPLE  = 3'd2,
    JOB_TTYPE   = 3'd3,
    JOB_OFFERS  = 3'd4
  } job_kind_t;

  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] verb;   // reply verb of a triple
    logic [7:0] value;  // data byte or option
    logic       echo;   // echo flag after the step
    logic [1:0] term;   // terminal kind for ttype is
  } job_t;

  function automatic logic [2:0] name_len(input logic [1:0] k);
    name_len = (k == 2'd1) ? 3'd5 : 3'd4;
  endfunction

  function automatic logic [7:0] name_char(input logic [1:0] k, input logic [2:0] i);
    logic [39:0] s;
    begin
      unique case (k)
        2'd0:    s = {"VT52", 8'd0};
        2'd1:    s = "VT100";
        2'd2:    s = {"ANSI", 8'd0};
        default: s = {"DUMB", 8'd0};
      endcase
      case (i)
        3'd0:    name_char = s[39:32];
        3'd1:    name_char = s[31:24];
        3'd2:    name_char = s[23:16];
        3'd3:    name_char = s[15:8];
        default: name_char = s[7:0];
      endcase
    end
  endfunction

  function automatic logic [3:0] job_len(input job_t j);
    unique case (j.kind)
      JOB_TO_HOST: job_len = 4'd1;
      JOB_TO_NET:  job_len = (j.value == B_IAC) ? 4'd2 : 4'd1;
      JOB_TRIPLE:  job_len = 4'd3;
      JOB_TTYPE:   job_len = 4'd6 + {1'b0, name_len(j.term)};
      JOB_OFFERS:  job_len = 4'd12;
      default:     job_len = 4'd1;
    endcase
  endfunction

  function automatic logic [7:0] job_byte(input job_t j, input logic [3:0] idx);
    logic [3:0] n;
    begin
      n = idx - 4'd4;
      unique case (j.kind)
        JOB_TO_HOST, JOB_TO_NET: job_byte = j.value;
        JOB_TRIPLE: begin
          case (idx)
            4'd0:    job_byte = B_IAC;
            4'd1:    job_byte = j.verb;
            default: job_byte = j.value;
          endcase
        end
        JOB_TTYPE: begin
          if (idx == 4'd0) job_byte = B_IAC;
          else if (idx == 4'd1) job_byte = B_SB;
          else if (idx == 4'd2) job_byte = OPT_TTYPE;
          else if (idx == 4'd3) job_byte = TT_IS;
          else if (n < {1'b0, name_len(j.term)}) job_byte = name_char(j.term, n[2:0]);
          else if (n == {1'b0, name_len(j.term)}) job_byte = B_IAC;
          else job_byte = B_SE;
        end
        JOB_OFFERS: begin
          case (idx)
            4'd1:    job_byte = B_WONT;
            4'd2:    job_byte = OPT_ECHO;
            4'd4:    job_byte = B_WILL;
            4'd5:    job_byte = OPT_TTYPE;
            4'd7:    job_byte = B_WONT;
            4'd8:    job_byte = OPT_COMP2;
            4'd10:   job_byte = B_WONT;
            4'd11:   job_byte = OPT_MSSP;
            default: job_byte = B_IAC;
          endcase
        end
        default: job_byte = j.value;
      endcase
    end
  endfunction

endpackage

`default_nettype wire

[hw/rtl/tof_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module tof_front
  import tof_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_word_t in_word,
  input  wire logic [1:0] terminal_kind,
  input  wire logic     q_full,
  output logic          q_push,
  output job_t          q_job
);

  typedef enum logic [2:0] {
    PH_DATA   = 3'd0,
    PH_IAC    = 3'd1,
    PH_OPT    = 3'd2,
    PH_SBOPT  = 3'd3,
    PH_SB1    = 3'd4,
    PH_SBBODY = 3'd5,
    PH_SBIAC  = 3'd6
  } phase_t;

  localparam logic [1:0] VERB_DO   = 2'd0;
  localparam logic [1:0] VERB_DONT = 2'd1;
  localparam logic [1:0] VERB_WILL = 2'd2;
  localparam logic [1:0] VERB_WONT = 2'd3;

  phase_t     phase, phase_next;
  logic [1:0] pending_verb, pending_verb_next;
  logic [7:0] sub_option, sub_option_next;
  logic       sub_reply, sub_reply_next;
  logic       echo_on, echo_on_next;
  logic       job_valid;
  job_t       job;
  logic       fire;
  logic [7:0] b;

  assign in_ready = !q_full;
  assign fire     = in_valid && in_ready;
  assign b        = in_word.data_byte;

  always_comb begin
    phase_next        = phase;
    pending_verb_next = pending_verb;
    sub_option_next   = sub_option;
    sub_reply_next    = sub_reply;
    echo_on_next      = echo_on;
    job_valid         = 1'b0;
    job.kind          = JOB_TO_HOST;
    job.verb          = 8'd0;
    job.value         = b;
    job.term          = terminal_kind;
    case (in_word.action)
      ACT_NET: begin
        unique case (phase)
          PH_IAC: begin
            phase_next = PH_DATA;
            if (b == B_IAC) begin
              job_valid = 1'b1;
            end else if (b == B_DO) begin
              pending_verb_next = VERB_DO;
              phase_next        = PH_OPT;
            end else if (b == B_DONT) begin
              pending_verb_next = VERB_DONT;
              phase_next        = PH_OPT;
            end else if (b == B_WILL) begin
              pending_verb_next = VERB_WILL;
              phase_next        = PH_OPT;
            end else if (b == B_WONT) begin
              pending_verb_next = VERB_WONT;
              phase_next        = PH_OPT;
            end else if (b == B_SB) begin
              phase_next = PH_SBOPT;
            end
          end
          PH_OPT: begin
            phase_next = PH_DATA;
            if (b == OPT_ECHO && pending_verb == VERB_WILL) echo_on_next = 1'b0;
            if (b == OPT_ECHO && pending_verb == VERB_WONT) echo_on_next = 1'b1;
            job.kind = JOB_TRIPLE;
            if (pending_verb == VERB_DO) begin
              job_valid = 1'b1;
              job.verb  = (b == OPT_TTYPE) ? B_WILL : B_WONT;
            end else if (pending_verb == VERB_WILL) begin
              job_valid = 1'b1;
              job.verb  = (b == OPT_TTYPE) ? B_DO : B_DONT;
            end
          end
          PH_SBOPT: begin
            sub_option_next = b;
            sub_reply_next  = 1'b0;
            phase_next      = PH_SB1;
          end
          PH_SB1: begin
            if (b == B_IAC) begin
              sub_reply_next = 1'b0;
              phase_next     = PH_SBIAC;
            end else begin
              sub_reply_next = (sub_option == OPT_TTYPE) && (b == TT_SEND);
              phase_next     = PH_SBBODY;
            end
          end
          PH_SBBODY: begin
            if (b == B_IAC) phase_next = PH_SBIAC;
          end
          PH_SBIAC: begin
            if (b == B_SE) begin
              job_valid      = sub_reply;
              job.kind       = JOB_TTYPE;
              sub_reply_next = 1'b0;
              phase_next     = PH_DATA;
            end else begin
              phase_next = PH_SBBODY;
            end
          end
          default: begin
            // data phase, and the unused code
            if (b == B_IAC) begin
              phase_next = PH_IAC;
            end else begin
              job_valid  = 1'b1;
              phase_next = PH_DATA;
            end
          end
        endcase
      end
      ACT_HOST: begin
        job_valid = 1'b1;
        job.kind  = JOB_TO_NET;
      end
      ACT_CONNECT: begin
        phase_next     = PH_DATA;
        sub_reply_next = 1'b0;
        job_valid      = 1'b1;
        job.kind       = JOB_OFFERS;
      end
      default: begin
      end
    endcase
    job.echo = echo_on_next;
  end

  assign q_push = fire && job_valid;
  assign q_job  = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_DATA;
      pending_verb <= VERB_DO;
      sub_option   <= 8'd0;
      sub_reply    <= 1'b0;
      echo_on      <= 1'b1;
    end else if (fire) begin
      phase        <= phase_next;
      pending_verb <= pending_verb_next;
      sub_option   <= sub_option_next;
      sub_reply    <= sub_reply_next;
      echo_on      <= echo_on_next;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/tof_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module tof_queue
  import tof_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  output logic      full,
  input  wire logic pop,
  output logic      head_valid,
  output job_t      head_job
);

  job_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_pop;

  assign full       = (count == (QPTR_W+1)'(QDEPTH));
  assign head_valid = (count != '0);
  assign head_job   = mem[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !do_pop) count <= count + 1'b1;
      else if (!push && do_pop) count <= count - 1'b1;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/tof_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module tof_back
  import tof_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      head_valid,
  input  wire job_t      head_job,
  output logic           pop,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_word_t      out_word
);

  logic [3:0] idx;
  logic [3:0] len;
  logic       load;
  logic       last;

  assign len  = job_len(head_job);
  assign last = (idx == len - 4'd1);
  assign load = head_valid && (!out_valid || out_ready);
  assign pop  = load && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 4'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= last ? 4'd0 : idx + 4'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_word.to_network   <= (head_job.kind != JOB_TO_HOST);
      out_word.out_byte     <= job_byte(head_job, idx);
      out_word.last_of_run  <= last;
      out_word.echo_enabled <= head_job.echo;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/telnet_option_filter.sv]
// telnet option filter between a terminal (host side) and a network link
//
// input channel in_valid/in_ready/in_word: one word per item, action plus byte
// (network byte, host byte, or connection-opened event)
// output channel out_valid/out_ready/out_word: zero to twelve words per item,
// each tagged with its destination, last_of_run on the final one, and the
// echo flag as it stands after the item
// config: cfg_we/cfg_wdata writes terminal_kind (vt52, vt100, ansi, dumb),
// registered, reset value dumb
//
// with the emitter idle, an accepted item is first written into the job queue and
// its first word is then loaded into the output register that drives out_word
// throughput: one item per cycle in while the queue is not full, and one word per
// cycle out while the receiver is ready; a job holds the queue head for its run
// the 4-entry job queue lets the parser keep taking bytes while a long reply
// (connect offers, ttype is) drains; in_ready drops only when the queue is full
// items with no result (commands, subnegotiation body) never enter the queue
// when the receiver stalls, out_word holds and the emitter waits
// reset (rst, synchronous) returns the parser to the data phase, sets echo on,
// empties the queue and drops out_valid
`timescale 1ns / 1ps
`default_nettype none

module telnet_option_filter
  import tof_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire in_word_t   in_word,
  output logic            out_valid,
  input  wire logic       out_ready,
  output out_word_t       out_word,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_wdata
);

  logic [1:0] terminal_kind;
  logic       q_full;
  logic       q_push;
  job_t       q_job;
  logic       q_pop;
  logic       head_valid;
  job_t       head_job;

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      terminal_kind <= 2'd3;
    end else if (cfg_we) begin
      terminal_kind <= cfg_wdata;
    end
  end

  // parser: classifies each item into a job, or into none
  tof_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_word       (in_word),
    .terminal_kind (terminal_kind),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_job         (q_job)
  );

  // decouples parser from emitter
  tof_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_job   (q_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // emitter: expands a job into output words
  tof_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_word   (out_word)
  );

endmodule

`default_nettype wire

[hw/rtl/tof_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module tof_checker
  import tof_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire out_word_t  out_word
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("output word dropped or changed under stall");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  a_host_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_word.to_network |-> out_word.last_of_run)
    else $error("host word not alone in its run");

  a_echo_in_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_word.last_of_run |=>
      !out_valid || (out_word.echo_enabled == $past(out_word.echo_enabled)))
    else $error("echo flag changed within a run");

endmodule

bind telnet_option_filter tof_checker u_tof_checker (.*);

`default_nettype wire
